// ----- design/nns_pkg.sv -----
package nns_pkg;

  localparam int MAX_DIM_DEF  = 256;
  localparam int MAX_CHN_DEF  = 4;
  localparam int COORD_W      = 8;
  localparam int DIM_W        = 9;
  localparam int CHN_W        = 3;
  localparam int PIX_W        = 32;
  localparam int OFF_W        = 18;
  localparam int IDX_W        = 18;
  localparam int NUM_W        = COORD_W + DIM_W;
  localparam int QW           = DIM_W;
  localparam int CFG_IDX_W    = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_DST_W = 3'd2,
    REG_DST_H = 3'd3,
    REG_CHN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [CHN_W-1:0] chn;
  } cfg_t;

  typedef struct packed {
    logic             fetch;
    logic             ok;
    logic [PIX_W-1:0] pixel;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [IDX_W-1:0] ld_idx;
    logic [IDX_W-1:0] didx;
  } req_t;

  function automatic logic [PIX_W-1:0] chan_mask(input logic [CHN_W-1:0] chn);
    logic [PIX_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIX_W / 8; i++) begin
      if (CHN_W'(i) < chn) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ----- design/nns_ram.sv -----
module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ----- design/nns_front.sv -----
module nns_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          opcode,
  input  logic [nns_pkg::COORD_W-1:0]   coord_x,
  input  logic [nns_pkg::COORD_W-1:0]   coord_y,
  input  logic [nns_pkg::PIX_W-1:0]     pixel_in,
  input  nns_pkg::cfg_t                 cfg,
  output logic                          valid,
  output nns_pkg::req_t                 req
);

  logic          valid_r;
  nns_pkg::req_t req_r, req_nxt;
  logic          in_src, in_dst;

  always_comb begin
    in_src = (nns_pkg::DIM_W'(coord_x) < cfg.sw) && (nns_pkg::DIM_W'(coord_y) < cfg.sh);
    in_dst = (nns_pkg::DIM_W'(coord_x) < cfg.tw) && (nns_pkg::DIM_W'(coord_y) < cfg.th);
    req_nxt.fetch  = (opcode == nns_pkg::OP_FETCH);
    req_nxt.ok     = (opcode == nns_pkg::OP_FETCH) ? in_dst : in_src;
    req_nxt.pixel  = pixel_in;
    req_nxt.num_x  = nns_pkg::NUM_W'(coord_x) * nns_pkg::NUM_W'(cfg.sw);
    req_nxt.num_y  = nns_pkg::NUM_W'(coord_y) * nns_pkg::NUM_W'(cfg.sh);
    req_nxt.ld_idx = nns_pkg::IDX_W'(coord_x) + nns_pkg::IDX_W'(coord_y) * nns_pkg::IDX_W'(cfg.sw);
    req_nxt.didx   = nns_pkg::IDX_W'(coord_x) + nns_pkg::IDX_W'(coord_y) * nns_pkg::IDX_W'(cfg.tw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  assign valid = valid_r;
  assign req   = req_r;

endmodule

// ----- design/nns_queue.sv -----
module nns_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nns_pkg::req_t push_data,
  output logic          pop,
  output nns_pkg::req_t pop_data,
  output logic          full
);

  nns_pkg::req_t mem_r [2];
  logic [1:0]    count_r, count_nxt;
  logic          wr_ptr_r, rd_ptr_r;

  assign pop      = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];
  assign full     = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/nns_back.sv -----
module nns_back #(
  parameter int MAX_DIM = nns_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  nns_pkg::req_t               in_req,
  input  nns_pkg::cfg_t               cfg,
  output logic                        out_strobe,
  output logic [nns_pkg::PIX_W-1:0]   pixel_out,
  output logic [nns_pkg::OFF_W-1:0]   source_offset,
  output logic [nns_pkg::OFF_W-1:0]   target_offset,
  output logic                        status
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WIDE_W = nns_pkg::NUM_W + nns_pkg::QW;

  typedef struct packed {
    logic                       valid;
    nns_pkg::req_t              req;
    logic [nns_pkg::NUM_W-1:0]  rx;
    logic [nns_pkg::NUM_W-1:0]  ry;
    logic [nns_pkg::QW-1:0]     qx;
    logic [nns_pkg::QW-1:0]     qy;
  } div_t;

  typedef struct packed {
    logic                       valid;
    logic                       fetch;
    logic                       ok;
    logic [nns_pkg::PIX_W-1:0]  pixel;
    logic [nns_pkg::IDX_W-1:0]  ld_idx;
    logic [nns_pkg::IDX_W-1:0]  sidx;
    logic [nns_pkg::OFF_W-1:0]  toff;
  } idx_t;

  typedef struct packed {
    logic                       valid;
    logic                       fetch;
    logic                       ok;
    logic                       hit;
    logic [nns_pkg::OFF_W-1:0]  soff;
    logic [nns_pkg::OFF_W-1:0]  toff;
  } rd_t;

  div_t  st_r [nns_pkg::QW+1];
  idx_t  ix_r, ix_nxt;
  rd_t   rd_r, rd_nxt;

  logic                      strobe_r, status_r;
  logic [nns_pkg::PIX_W-1:0] pix_r;
  logic [nns_pkg::OFF_W-1:0] soff_r, toff_r;

  logic [nns_pkg::IDX_W-1:0] addr_idx;
  logic                      addr_hit, ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [nns_pkg::PIX_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].valid <= 1'b0;
    end else begin
      st_r[0].valid <= in_valid;
    end
    st_r[0].req <= in_req;
    st_r[0].rx  <= in_req.num_x;
    st_r[0].ry  <= in_req.num_y;
    st_r[0].qx  <= '0;
    st_r[0].qy  <= '0;
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < nns_pkg::QW; k++) begin : g_div
    localparam int B = nns_pkg::QW - 1 - k;
    logic [WIDE_W-1:0] dx, dy;
    logic              gx, gy;
    div_t              nxt;

    always_comb begin
      dx  = WIDE_W'(cfg.tw) << B;
      dy  = WIDE_W'(cfg.th) << B;
      gx  = WIDE_W'(st_r[k].rx) >= dx;
      gy  = WIDE_W'(st_r[k].ry) >= dy;
      nxt = st_r[k];
      if (gx) nxt.rx = st_r[k].rx - nns_pkg::NUM_W'(dx);
      if (gy) nxt.ry = st_r[k].ry - nns_pkg::NUM_W'(dy);
      nxt.qx[B] = gx;
      nxt.qy[B] = gy;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].valid <= 1'b0;
      end else begin
        st_r[k+1].valid <= nxt.valid;
      end
      st_r[k+1].req <= nxt.req;
      st_r[k+1].rx  <= nxt.rx;
      st_r[k+1].ry  <= nxt.ry;
      st_r[k+1].qx  <= nxt.qx;
      st_r[k+1].qy  <= nxt.qy;
    end
  end

  always_comb begin
    ix_nxt.valid  = st_r[nns_pkg::QW].valid;
    ix_nxt.fetch  = st_r[nns_pkg::QW].req.fetch;
    ix_nxt.ok     = st_r[nns_pkg::QW].req.ok;
    ix_nxt.pixel  = st_r[nns_pkg::QW].req.pixel;
    ix_nxt.ld_idx = st_r[nns_pkg::QW].req.ld_idx;
    ix_nxt.sidx   = nns_pkg::IDX_W'(st_r[nns_pkg::QW].qx)
                  + nns_pkg::IDX_W'(st_r[nns_pkg::QW].qy) * nns_pkg::IDX_W'(cfg.sw);
    ix_nxt.toff   = nns_pkg::OFF_W'(st_r[nns_pkg::QW].req.didx
                  * nns_pkg::IDX_W'(cfg.chn));
  end

  always_comb begin
    addr_idx = ix_r.fetch ? ix_r.sidx : ix_r.ld_idx;
    addr_hit = (32'(addr_idx) < 32'(DEPTH));
    ram_addr = ADDR_W'(addr_idx);
    ram_we   = ix_r.valid && !ix_r.fetch && ix_r.ok && addr_hit;
    rd_nxt.valid = ix_r.valid;
    rd_nxt.fetch = ix_r.fetch;
    rd_nxt.ok    = ix_r.ok;
    rd_nxt.hit   = addr_hit;
    rd_nxt.soff  = nns_pkg::OFF_W'(ix_r.sidx * nns_pkg::IDX_W'(cfg.chn));
    rd_nxt.toff  = ix_r.toff;
  end

  nns_ram #(
    .WIDTH (nns_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ix_r.pixel),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_r.valid <= 1'b0;
      rd_r.valid <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      ix_r.valid <= ix_nxt.valid;
      rd_r.valid <= rd_nxt.valid;
      strobe_r   <= rd_r.valid && rd_r.fetch;
    end
    ix_r.fetch  <= ix_nxt.fetch;
    ix_r.ok     <= ix_nxt.ok;
    ix_r.pixel  <= ix_nxt.pixel;
    ix_r.ld_idx <= ix_nxt.ld_idx;
    ix_r.sidx   <= ix_nxt.sidx;
    ix_r.toff   <= ix_nxt.toff;
    rd_r.fetch  <= rd_nxt.fetch;
    rd_r.ok     <= rd_nxt.ok;
    rd_r.hit    <= rd_nxt.hit;
    rd_r.soff   <= rd_nxt.soff;
    rd_r.toff   <= rd_nxt.toff;
    status_r    <= !rd_r.ok;
    pix_r       <= (rd_r.ok && rd_r.hit) ? (ram_rdata & nns_pkg::chan_mask(cfg.chn)) : '0;
    soff_r      <= rd_r.ok ? rd_r.soff : '0;
    toff_r      <= rd_r.ok ? rd_r.toff : '0;
  end

  assign out_strobe    = strobe_r;
  assign pixel_out     = pix_r;
  assign source_offset = soff_r;
  assign target_offset = toff_r;
  assign status        = status_r;

endmodule

// ----- design/nearest_neighbor_scaler.sv -----
// nearest-neighbour scaler: takes one request per clock and returns each fetch result as a
// one-cycle out_strobe pulse; loads give no result. path: front reg, queue, nine-stage
// quotient pipeline, index reg, frame store read, output reg. the result side cannot stall,
// so busy stays low and config may be written once results have drained
module nearest_neighbor_scaler #(
  parameter int MAX_DIM      = nns_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = nns_pkg::MAX_CHN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [nns_pkg::COORD_W-1:0]     in_coord_x,
  input  logic [nns_pkg::COORD_W-1:0]     in_coord_y,
  input  logic [nns_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                            out_strobe,
  output logic [nns_pkg::PIX_W-1:0]       out_pixel_out,
  output logic [nns_pkg::OFF_W-1:0]       out_source_offset,
  output logic [nns_pkg::OFF_W-1:0]       out_target_offset,
  output logic                            out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nns_pkg::DIM_W-1:0]       cfg_data
);

  localparam logic [nns_pkg::DIM_W-1:0] DIM_RST =
    nns_pkg::DIM_W'((256 > MAX_DIM) ? MAX_DIM : 256);
  localparam logic [nns_pkg::CHN_W-1:0] CHN_RST =
    nns_pkg::CHN_W'((4 > MAX_CHANNELS) ? MAX_CHANNELS : 4);

  nns_pkg::cfg_t cfg_r;
  logic [nns_pkg::DIM_W-1:0] dim_nxt;
  logic [nns_pkg::CHN_W-1:0] chn_nxt, chn_raw;

  logic          accept, fr_valid, q_pop, q_full;
  nns_pkg::req_t fr_req, q_req;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = q_full;

  // clamp written values into range
  always_comb begin
    chn_raw = cfg_data[nns_pkg::CHN_W-1:0];
    if (cfg_data == '0) begin
      dim_nxt = nns_pkg::DIM_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
      dim_nxt = nns_pkg::DIM_W'(MAX_DIM);
    end else begin
      dim_nxt = cfg_data;
    end
    if (chn_raw == '0) begin
      chn_nxt = nns_pkg::CHN_W'(1);
    end else if (32'(chn_raw) > 32'(MAX_CHANNELS)) begin
      chn_nxt = nns_pkg::CHN_W'(MAX_CHANNELS);
    end else begin
      chn_nxt = chn_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sw  <= DIM_RST;
      cfg_r.sh  <= DIM_RST;
      cfg_r.tw  <= DIM_RST;
      cfg_r.th  <= DIM_RST;
      cfg_r.chn <= CHN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nns_pkg::REG_SRC_W: cfg_r.sw  <= dim_nxt;
        nns_pkg::REG_SRC_H: cfg_r.sh  <= dim_nxt;
        nns_pkg::REG_DST_W: cfg_r.tw  <= dim_nxt;
        nns_pkg::REG_DST_H: cfg_r.th  <= dim_nxt;
        nns_pkg::REG_CHN:   cfg_r.chn <= chn_nxt;
        default: begin
        end
      endcase
    end
  end

  nns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .opcode   (in_opcode),
    .coord_x  (in_coord_x),
    .coord_y  (in_coord_y),
    .pixel_in (in_pixel_in),
    .cfg      (cfg_r),
    .valid    (fr_valid),
    .req      (fr_req)
  );

  nns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_data (fr_req),
    .pop       (q_pop),
    .pop_data  (q_req),
    .full      (q_full)
  );

  nns_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (q_pop),
    .in_req        (q_req),
    .cfg           (cfg_r),
    .out_strobe    (out_strobe),
    .pixel_out     (out_pixel_out),
    .source_offset (out_source_offset),
    .target_offset (out_target_offset),
    .status        (out_status)
  );

  // back end drains every cycle, so the queue never fills
  assert property (@(posedge clk) disable iff (!rst_n) !q_full)
    else $error("request queue full");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |->
      (out_pixel_out == '0 && out_source_offset == '0 && out_target_offset == '0))
    else $error("out of range fetch with nonzero payload");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid && q_pop) |=> q_pop)
    else $error("queue lost a request");

endmodule
